>>> rtl/core/wshc_pkg.sv
// ============================================================================
// wshc_pkg
// Types and constants shared by the window size-hint constrainer pipeline
// ============================================================================
`default_nettype none

package wshc_pkg;

    // width of positions while they are being clamped to the bounding rectangle
    localparam int POS_W = 22;
    // width of sizes once aspect limits may have scaled them
    localparam int VAL_W = 33;
    // magnitude bits fed through the remainder pipeline
    localparam int MAG_BITS = 31;
    // remainder width, an increment is at most 16 bits
    localparam int REM_W = 16;
    // product of a 15-bit size and a 32-bit Q16.16 aspect limit
    localparam int PROD_W = 47;
    localparam int CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MONITOR_RECT  = 4'd0,
        REG_WORK_RECT     = 4'd1,
        REG_BAR_HEIGHT    = 4'd2,
        REG_HONOR_HINTS   = 4'd3,
        REG_LAYOUT_TILES  = 4'd4,
        REG_SIZE_LIMITS   = 4'd5,
        REG_BASE_AND_STEP = 4'd6,
        REG_ASPECT_LIMITS = 4'd7
    } cfg_reg_t;

    // first stage: position after the far-edge rule, sizes forced to at least 1
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [14:0]             w;
        logic [14:0]             h;
        logic [7:0]              border;
        logic                    use_monitor;
        logic                    hint;
        logic signed [15:0]      cur_x;
        logic signed [15:0]      cur_y;
        logic [14:0]             cur_w;
        logic [14:0]             cur_h;
    } s1_t;

    // fields carried unchanged from the second stage to the output
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [14:0]             w_byp;
        logic [14:0]             h_byp;
        logic                    hint;
        logic signed [15:0]      cur_x;
        logic signed [15:0]      cur_y;
        logic [14:0]             cur_w;
        logic [14:0]             cur_h;
    } carry_t;

    typedef struct packed {
        carry_t             c;
        logic signed [16:0] wa;
        logic signed [16:0] ha;
    } s2_t;

    typedef struct packed {
        carry_t             c;
        logic signed [16:0] wa;
        logic signed [16:0] ha;
        logic [PROD_W-1:0]  pw;
        logic [PROD_W-1:0]  ph;
    } s3_t;

    typedef struct packed {
        carry_t                  c;
        logic signed [VAL_W-1:0] w;
        logic signed [VAL_W-1:0] h;
    } sz_t;

    typedef struct packed {
        carry_t              c;
        logic [MAG_BITS-1:0] mag_w;
        logic [MAG_BITS-1:0] mag_h;
        logic                neg_w;
        logic                neg_h;
        logic [REM_W-1:0]    rem_w;
        logic [REM_W-1:0]    rem_h;
    } div_t;

    // one restoring step of the remainder; a zero divisor leaves garbage that is masked later
    function automatic logic [REM_W-1:0] rem_step(
        input logic [REM_W-1:0] r,
        input logic             b,
        input logic [REM_W-1:0] d
    );
        logic [REM_W:0] trial;
        trial = {r, b};
        if ((d != '0) && (trial >= {1'b0, d}))
        begin
            trial = trial - {1'b0, d};
        end
        return trial[REM_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/window_size_hint_constrainer_top.sv
// ============================================================================
// window_size_hint_constrainer_top
// Clamps a requested window rectangle to its monitor and applies size hints
// ============================================================================
// Usage:
//  - request channel in_valid/in_ready carries the requested rectangle, the
//    window's current rectangle, its border and its dock/floating/interactive
//    flags; one result per request leaves on out_valid/out_ready
//  - configuration registers are written over cfg_valid/cfg_ready with
//    cfg_index and cfg_data; cfg_ready is always high, writes take effect at
//    once and must only happen while the pipeline is empty
//  - a new request is taken every cycle while the output is not stalled; the
//    remainder pipeline for the size increments (one quotient bit per stage)
//    sets the depth
//  - every stage holds its transaction while the next one is full and held, so
//    a stall on out_ready fills bubbles first and then backs up to in_ready;
//    nothing is lost or repeated
//  - reset empties the pipeline and loads the register defaults: all zero
//    apart from layout_tiles, which comes up set
// ============================================================================
`default_nettype none

module window_size_hint_constrainer_top #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [wshc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [63:0]                       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [15:0]                req_x,
    input  wire logic signed [15:0]                req_y,
    input  wire logic signed [15:0]                req_w,
    input  wire logic signed [15:0]                req_h,
    input  wire logic                              interactive,
    input  wire logic [7:0]                        border,
    input  wire logic                              is_dock,
    input  wire logic                              is_floating,
    input  wire logic signed [15:0]                cur_x,
    input  wire logic signed [15:0]                cur_y,
    input  wire logic [14:0]                       cur_w,
    input  wire logic [14:0]                       cur_h,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [15:0]                     new_x,
    output logic signed [15:0]                     new_y,
    output logic [14:0]                            new_w,
    output logic [14:0]                            new_h,
    output logic                                   changed
);

    import wshc_pkg::*;

    localparam logic signed [VAL_W-1:0] CMAX = VAL_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [VAL_W-1:0] CMIN = -CMAX - VAL_W'(1);
    localparam logic signed [VAL_W-1:0] ONE  = VAL_W'(1);

    // configuration registers
    logic [63:0] monitor_rect_reg;
    logic [63:0] work_rect_reg;
    logic [11:0] bar_height_reg;
    logic        honor_hints_reg;
    logic        layout_tiles_reg;
    logic [63:0] size_limits_reg;
    logic [63:0] base_and_step_reg;
    logic [63:0] aspect_limits_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            monitor_rect_reg  <= '0;
            work_rect_reg     <= '0;
            bar_height_reg    <= '0;
            honor_hints_reg   <= 1'b0;
            layout_tiles_reg  <= 1'b1;
            size_limits_reg   <= '0;
            base_and_step_reg <= '0;
            aspect_limits_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MONITOR_RECT:  monitor_rect_reg  <= cfg_data;
                REG_WORK_RECT:     work_rect_reg     <= cfg_data;
                REG_BAR_HEIGHT:    bar_height_reg    <= cfg_data[11:0];
                REG_HONOR_HINTS:   honor_hints_reg   <= cfg_data[0];
                REG_LAYOUT_TILES:  layout_tiles_reg  <= cfg_data[0];
                REG_SIZE_LIMITS:   size_limits_reg   <= cfg_data;
                REG_BASE_AND_STEP: base_and_step_reg <= cfg_data;
                REG_ASPECT_LIMITS: aspect_limits_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [15:0] minw, minh, maxw, maxh, basew, baseh, incw, inch;
    logic [31:0] mina, maxa;
    logic        base_is_min;

    assign minw  = size_limits_reg[63:48];
    assign minh  = size_limits_reg[47:32];
    assign maxw  = size_limits_reg[31:16];
    assign maxh  = size_limits_reg[15:0];
    assign basew = base_and_step_reg[63:48];
    assign baseh = base_and_step_reg[47:32];
    assign incw  = base_and_step_reg[31:16];
    assign inch  = base_and_step_reg[15:0];
    assign mina  = aspect_limits_reg[63:32];
    assign maxa  = aspect_limits_reg[31:0];
    assign base_is_min = (basew == minw) && (baseh == minh);

    // pipeline valid bits, payload and stage enables
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, e1_v_reg, e2_v_reg, out_v_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    sz_t  s4_reg, s4_next;
    sz_t  e1_reg, e1_next;
    sz_t  e2_reg, e2_next;
    div_t div_reg [0:MAG_BITS];
    div_t div_next [0:MAG_BITS];
    logic div_v_reg [0:MAG_BITS];
    logic div_en [0:MAG_BITS];
    logic en1, en2, en3, en4, en_e1, en_e2, en_out;

    assign en_out = !out_v_reg || out_ready;
    assign en_e2  = !e2_v_reg || en_out;
    assign en_e1  = !e1_v_reg || en_e2;
    assign div_en[MAG_BITS] = !div_v_reg[MAG_BITS] || en_e1;
    for (genvar k = 0; k < MAG_BITS; k++)
    begin : g_div_en
        assign div_en[k] = !div_v_reg[k] || div_en[k+1];
    end
    assign en4 = !s4_v_reg || div_en[0];
    assign en3 = !s3_v_reg || en4;
    assign en2 = !s2_v_reg || en3;
    assign en1 = !s1_v_reg || en2;
    assign in_ready = en1;

    // stage 1: far-edge rule, sizes forced to at least 1
    always_comb
    begin
        logic [63:0]             rect;
        logic signed [POS_W-1:0] edge_x, edge_y, outer_w, outer_h, rx, ry;
        rect    = (interactive || is_dock) ? monitor_rect_reg : work_rect_reg;
        edge_x  = $signed({{(POS_W-16){rect[63]}}, rect[63:48]})
                + $signed({{(POS_W-16){1'b0}}, rect[31:16]});
        edge_y  = $signed({{(POS_W-16){rect[47]}}, rect[47:32]})
                + $signed({{(POS_W-16){1'b0}}, rect[15:0]});
        outer_w = $signed({{(POS_W-15){1'b0}}, cur_w})
                + $signed({{(POS_W-9){1'b0}}, border, 1'b0});
        outer_h = $signed({{(POS_W-15){1'b0}}, cur_h})
                + $signed({{(POS_W-9){1'b0}}, border, 1'b0});
        rx = $signed({{(POS_W-16){req_x[15]}}, req_x});
        ry = $signed({{(POS_W-16){req_y[15]}}, req_y});
        s1_next.x = (rx >= edge_x) ? edge_x - outer_w : rx;
        s1_next.y = (ry >= edge_y) ? edge_y - outer_h : ry;
        s1_next.w = (req_w < 16'sd1) ? 15'd1 : req_w[14:0];
        s1_next.h = (req_h < 16'sd1) ? 15'd1 : req_h[14:0];
        s1_next.border      = border;
        s1_next.use_monitor = interactive || is_dock;
        s1_next.hint  = !interactive && (honor_hints_reg || is_floating || !layout_tiles_reg);
        s1_next.cur_x = cur_x;
        s1_next.cur_y = cur_y;
        s1_next.cur_w = cur_w;
        s1_next.cur_h = cur_h;
    end

    // stage 2: near-edge rule, bar floor, base taken off ahead of the aspect step unless it equals the minimum
    always_comb
    begin
        logic [63:0]             rect;
        logic signed [POS_W-1:0] bx, by, reach_x, reach_y;
        logic [14:0]             w2, h2;
        rect = s1_reg.use_monitor ? monitor_rect_reg : work_rect_reg;
        bx   = $signed({{(POS_W-16){rect[63]}}, rect[63:48]});
        by   = $signed({{(POS_W-16){rect[47]}}, rect[47:32]});
        reach_x = s1_reg.x + $signed({{(POS_W-15){1'b0}}, s1_reg.w})
                + $signed({{(POS_W-9){1'b0}}, s1_reg.border, 1'b0});
        reach_y = s1_reg.y + $signed({{(POS_W-15){1'b0}}, s1_reg.h})
                + $signed({{(POS_W-9){1'b0}}, s1_reg.border, 1'b0});
        w2 = (s1_reg.w < {3'b0, bar_height_reg}) ? {3'b0, bar_height_reg} : s1_reg.w;
        h2 = (s1_reg.h < {3'b0, bar_height_reg}) ? {3'b0, bar_height_reg} : s1_reg.h;
        s2_next.c.x     = (reach_x <= bx) ? bx : s1_reg.x;
        s2_next.c.y     = (reach_y <= by) ? by : s1_reg.y;
        s2_next.c.w_byp = w2;
        s2_next.c.h_byp = h2;
        s2_next.c.hint  = s1_reg.hint;
        s2_next.c.cur_x = s1_reg.cur_x;
        s2_next.c.cur_y = s1_reg.cur_y;
        s2_next.c.cur_w = s1_reg.cur_w;
        s2_next.c.cur_h = s1_reg.cur_h;
        if (base_is_min)
        begin
            s2_next.wa = $signed({2'b0, w2});
            s2_next.ha = $signed({2'b0, h2});
        end
        else
        begin
            s2_next.wa = $signed({2'b0, w2}) - $signed({1'b0, basew});
            s2_next.ha = $signed({2'b0, h2}) - $signed({1'b0, baseh});
        end
    end

    // stage 3: aspect products, each one used for both the compare and the new size
    always_comb
    begin
        s3_next.c  = s2_reg.c;
        s3_next.wa = s2_reg.wa;
        s3_next.ha = s2_reg.ha;
        s3_next.pw = (s2_reg.ha > 17'sd0) ? PROD_W'(s2_reg.ha[14:0]) * PROD_W'(maxa) : '0;
        s3_next.ph = (s2_reg.wa > 17'sd0) ? PROD_W'(s2_reg.wa[14:0]) * PROD_W'(mina) : '0;
    end

    // stage 4: aspect limits, round half up
    always_comb
    begin
        logic              on, fix_w, fix_h;
        logic [PROD_W-1:0] wide_w, wide_h;
        logic [PROD_W:0]   rnd_w, rnd_h;
        on     = (mina != '0) && (maxa != '0);
        wide_w = PROD_W'({s3_reg.wa[14:0], 16'b0});
        wide_h = PROD_W'({s3_reg.ha[14:0], 16'b0});
        fix_w  = on && (s3_reg.ha > 17'sd0) && (s3_reg.wa > 17'sd0) && (s3_reg.pw < wide_w);
        fix_h  = on && !fix_w && (s3_reg.wa > 17'sd0) && (s3_reg.ha > 17'sd0)
                 && (s3_reg.ph < wide_h);
        rnd_w  = {1'b0, s3_reg.pw} + (PROD_W+1)'(32768);
        rnd_h  = {1'b0, s3_reg.ph} + (PROD_W+1)'(32768);
        s4_next.c = s3_reg.c;
        s4_next.w = fix_w ? $signed({1'b0, rnd_w[PROD_W:16]})
                          : $signed({{(VAL_W-17){s3_reg.wa[16]}}, s3_reg.wa});
        s4_next.h = fix_h ? $signed({1'b0, rnd_h[PROD_W:16]})
                          : $signed({{(VAL_W-17){s3_reg.ha[16]}}, s3_reg.ha});
    end

    // stage 5: base taken off after aspect when it equals the minimum, split into sign and magnitude
    always_comb
    begin
        logic signed [VAL_W-1:0] w5, h5, aw, ah;
        w5 = base_is_min ? s4_reg.w - $signed({{(VAL_W-16){1'b0}}, basew}) : s4_reg.w;
        h5 = base_is_min ? s4_reg.h - $signed({{(VAL_W-16){1'b0}}, baseh}) : s4_reg.h;
        aw = w5[VAL_W-1] ? -w5 : w5;
        ah = h5[VAL_W-1] ? -h5 : h5;
        div_next[0].c     = s4_reg.c;
        div_next[0].mag_w = aw[MAG_BITS-1:0];
        div_next[0].mag_h = ah[MAG_BITS-1:0];
        div_next[0].neg_w = w5[VAL_W-1];
        div_next[0].neg_h = h5[VAL_W-1];
        div_next[0].rem_w = '0;
        div_next[0].rem_h = '0;
    end

    // remainder pipeline, one magnitude bit a stage, msb first
    for (genvar k = 0; k < MAG_BITS; k++)
    begin : g_div
        always_comb
        begin
            div_next[k+1]       = div_reg[k];
            div_next[k+1].rem_w = rem_step(div_reg[k].rem_w,
                                           div_reg[k].mag_w[MAG_BITS-1-k], incw);
            div_next[k+1].rem_h = rem_step(div_reg[k].rem_h,
                                           div_reg[k].mag_h[MAG_BITS-1-k], inch);
        end
    end

    // end stage 1: round toward zero onto the increment, base added back
    always_comb
    begin
        logic [MAG_BITS-1:0]     qw, qh;
        logic signed [VAL_W-1:0] sw, sh;
        qw = div_reg[MAG_BITS].mag_w
           - ((incw != '0) ? MAG_BITS'(div_reg[MAG_BITS].rem_w) : '0);
        qh = div_reg[MAG_BITS].mag_h
           - ((inch != '0) ? MAG_BITS'(div_reg[MAG_BITS].rem_h) : '0);
        sw = $signed({{(VAL_W-MAG_BITS){1'b0}}, qw});
        sh = $signed({{(VAL_W-MAG_BITS){1'b0}}, qh});
        e1_next.c = div_reg[MAG_BITS].c;
        e1_next.w = (div_reg[MAG_BITS].neg_w ? -sw : sw)
                  + $signed({{(VAL_W-16){1'b0}}, basew});
        e1_next.h = (div_reg[MAG_BITS].neg_h ? -sh : sh)
                  + $signed({{(VAL_W-16){1'b0}}, baseh});
    end

    // end stage 2: min and max limits, hints dropped when they do not apply
    always_comb
    begin
        logic signed [VAL_W-1:0] w, h, lo_w, lo_h, hi_w, hi_h;
        lo_w = $signed({{(VAL_W-16){1'b0}}, minw});
        lo_h = $signed({{(VAL_W-16){1'b0}}, minh});
        hi_w = $signed({{(VAL_W-16){1'b0}}, maxw});
        hi_h = $signed({{(VAL_W-16){1'b0}}, maxh});
        w = (e1_reg.w < lo_w) ? lo_w : e1_reg.w;
        h = (e1_reg.h < lo_h) ? lo_h : e1_reg.h;
        if ((maxw != '0) && (w > hi_w))
        begin
            w = hi_w;
        end
        if ((maxh != '0) && (h > hi_h))
        begin
            h = hi_h;
        end
        e2_next.c = e1_reg.c;
        e2_next.w = e1_reg.c.hint ? w : $signed({{(VAL_W-15){1'b0}}, e1_reg.c.w_byp});
        e2_next.h = e1_reg.c.hint ? h : $signed({{(VAL_W-15){1'b0}}, e1_reg.c.h_byp});
    end

    // output stage: saturate to the coordinate range and compare with the current rectangle
    logic signed [VAL_W-1:0] sat_x, sat_y, sat_w, sat_h;
    logic                    chg_next;

    always_comb
    begin
        logic signed [VAL_W-1:0] px, py;
        px = $signed({{(VAL_W-POS_W){e2_reg.c.x[POS_W-1]}}, e2_reg.c.x});
        py = $signed({{(VAL_W-POS_W){e2_reg.c.y[POS_W-1]}}, e2_reg.c.y});
        sat_x = (px < CMIN) ? CMIN : ((px > CMAX) ? CMAX : px);
        sat_y = (py < CMIN) ? CMIN : ((py > CMAX) ? CMAX : py);
        sat_w = (e2_reg.w < ONE) ? ONE : ((e2_reg.w > CMAX) ? CMAX : e2_reg.w);
        sat_h = (e2_reg.h < ONE) ? ONE : ((e2_reg.h > CMAX) ? CMAX : e2_reg.h);
        chg_next = (sat_x != $signed({{(VAL_W-16){e2_reg.c.cur_x[15]}}, e2_reg.c.cur_x}))
                || (sat_y != $signed({{(VAL_W-16){e2_reg.c.cur_y[15]}}, e2_reg.c.cur_y}))
                || (sat_w != $signed({{(VAL_W-15){1'b0}}, e2_reg.c.cur_w}))
                || (sat_h != $signed({{(VAL_W-15){1'b0}}, e2_reg.c.cur_h}));
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            e1_v_reg  <= 1'b0;
            e2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)    s1_v_reg  <= in_valid;
            if (en2)    s2_v_reg  <= s1_v_reg;
            if (en3)    s3_v_reg  <= s2_v_reg;
            if (en4)    s4_v_reg  <= s3_v_reg;
            if (en_e1)  e1_v_reg  <= div_v_reg[MAG_BITS];
            if (en_e2)  e2_v_reg  <= e1_v_reg;
            if (en_out) out_v_reg <= e2_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_v_reg[0] <= 1'b0;
        end
        else if (div_en[0])
        begin
            div_v_reg[0] <= s4_v_reg;
        end
    end

    for (genvar k = 0; k < MAG_BITS; k++)
    begin : g_div_v
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_v_reg[k+1] <= 1'b0;
            end
            else if (div_en[k+1])
            begin
                div_v_reg[k+1] <= div_v_reg[k];
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en1)       s1_reg     <= s1_next;
        if (en2)       s2_reg     <= s2_next;
        if (en3)       s3_reg     <= s3_next;
        if (en4)       s4_reg     <= s4_next;
        if (div_en[0]) div_reg[0] <= div_next[0];
        if (en_e1)     e1_reg     <= e1_next;
        if (en_e2)     e2_reg     <= e2_next;
        if (en_out)
        begin
            new_x   <= sat_x[15:0];
            new_y   <= sat_y[15:0];
            new_w   <= sat_w[14:0];
            new_h   <= sat_h[14:0];
            changed <= chg_next;
        end
    end

    for (genvar k = 0; k < MAG_BITS; k++)
    begin : g_div_q
        always_ff @(posedge clk)
        begin
            if (div_en[k+1])
            begin
                div_reg[k+1] <= div_next[k+1];
            end
        end
    end

    assign out_valid = out_v_reg;

    // a stall can only start at the output
    a_stall_from_output : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while the output stage can move");

    // remainders leave the pipeline below their increment
    a_rem_w_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (div_v_reg[MAG_BITS] && (incw != '0)) |-> (div_reg[MAG_BITS].rem_w < incw))
        else $error("width remainder not below its increment");

    a_rem_h_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (div_v_reg[MAG_BITS] && (inch != '0)) |-> (div_reg[MAG_BITS].rem_h < inch))
        else $error("height remainder not below its increment");

endmodule

`default_nettype wire
